>>> rtl/decimated_boxcar_filter_macros.svh
// Assertion macros shared by the decimated boxcar filter modules.
`ifndef DECIMATED_BOXCAR_FILTER_MACROS_SVH
`define DECIMATED_BOXCAR_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DBF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DBF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dbf_pkg.sv
// Shared types and constants of the decimated boxcar filter.
`timescale 1ns / 1ps

package dbf_pkg;

	// register field widths
	localparam int CFG_W_FW  = 11;
	localparam int CFG_W_MW  = 11;
	localparam int CFG_W_DEC = 9;
	localparam int CFG_W_SL  = 25;
	localparam int CFG_DATA_W = 25;
	localparam int CFG_IDX_W  = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECIMATION    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SERIES_LENGTH = 2'd3;

	// datapath widths
	localparam int SUM_W   = 26;
	localparam int CNT_W   = 25;
	localparam int PHASE_W = 9;
	localparam int POS_W   = 34;
	localparam int CMP_W   = 35;
	localparam int OUT_TDATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// per-sample decisions taken at input transfer
	typedef struct packed {
		logic emit;
		logic last;
		logic first;
		logic leave_ok;
	} item_ctl_t;

	// window re-sum sweep controls
	typedef struct packed {
		logic clr;
		logic add;
	} sweep_ctl_t;

endpackage

>>> rtl/dbf_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
`timescale 1ns / 1ps

module dbf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

>>> rtl/dbf_ctrl.sv
// Configuration registers, series counters, delay-line addressing and re-sum sweep.
`timescale 1ns / 1ps

module dbf_ctrl #(
	parameter int MAX_WINDOW = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [dbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_first,
	input  logic                           take_ok,
	output logic                           in_ready,
	output logic                           accept,
	output dbf_pkg::item_ctl_t             item_ctl,
	output dbf_pkg::sweep_ctl_t            sweep,
	output logic                           ram_we,
	output logic [$clog2(MAX_WINDOW)-1:0]  ram_waddr,
	output logic                           ram_re,
	output logic [$clog2(MAX_WINDOW)-1:0]  ram_raddr
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int XW = ((AW > dbf_pkg::CFG_W_FW) ? AW : dbf_pkg::CFG_W_FW) + 1;
	localparam logic [XW-1:0] DEPTH_X = XW'(MAX_WINDOW);
	localparam int CW = dbf_pkg::CNT_W;
	localparam int PW = dbf_pkg::CMP_W;

	// step back d entries around the ring from p (d at most the depth)
	function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p,
			input logic [XW-1:0] d);
		logic [XW-1:0] px;
		px = XW'(p);
		if (d > px) begin
			ring_back = AW'(px + DEPTH_X - d);
		end else begin
			ring_back = AW'(px - d);
		end
	endfunction

	logic [dbf_pkg::CFG_W_FW-1:0]  fw_q, fw_eff;
	logic [dbf_pkg::CFG_W_MW-1:0]  mw_q, mw_eff;
	logic [dbf_pkg::CFG_W_DEC-1:0] dec_q, dec_eff;
	logic [dbf_pkg::CFG_W_SL-1:0]  sl_q;
	logic [dbf_pkg::CFG_W_MW-1:0]  start;
	logic signed [PW-1:0]          limit;

	logic [AW-1:0]                    wr_q, wr_cur, wr_next;
	logic [CW-1:0]                    count_q, n;
	logic [dbf_pkg::PHASE_W-1:0]      phase_q, phase, ph0, ph_next;
	logic [dbf_pkg::PHASE_W:0]        ph_inc;
	logic [CW-1:0]                    outcnt_q, outc;
	logic [dbf_pkg::POS_W-1:0]        pos_q, pos;
	logic signed [PW-1:0]             pos_x;
	logic                             started, emit;

	logic          rs_active_q, rs_add_q, rs_issue, rs_start;
	logic [XW-1:0] rs_k_q;
	logic          dec_fix_q, busy;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= dbf_pkg::CFG_W_FW'(1);
			mw_q  <= dbf_pkg::CFG_W_MW'(1);
			dec_q <= dbf_pkg::CFG_W_DEC'(1);
			sl_q  <= dbf_pkg::CFG_W_SL'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dbf_pkg::REG_FILTER_WIDTH:  fw_q  <= cfg_data[dbf_pkg::CFG_W_FW-1:0];
				dbf_pkg::REG_MAX_WIDTH:     mw_q  <= cfg_data[dbf_pkg::CFG_W_MW-1:0];
				dbf_pkg::REG_DECIMATION:    dec_q <= cfg_data[dbf_pkg::CFG_W_DEC-1:0];
				dbf_pkg::REG_SERIES_LENGTH: sl_q  <= cfg_data[dbf_pkg::CFG_W_SL-1:0];
				default: ;
			endcase
		end
	end

	// effective widths after clamping, window start and result limit
	always_comb begin
		if (mw_q == '0) begin
			mw_eff = dbf_pkg::CFG_W_MW'(1);
		end else if (XW'(mw_q) > DEPTH_X) begin
			mw_eff = dbf_pkg::CFG_W_MW'(MAX_WINDOW);
		end else begin
			mw_eff = mw_q;
		end
		if (fw_q == '0) begin
			fw_eff = dbf_pkg::CFG_W_FW'(1);
		end else if (fw_q > mw_eff) begin
			fw_eff = mw_eff;
		end else begin
			fw_eff = fw_q;
		end
		dec_eff = (dec_q == '0) ? dbf_pkg::CFG_W_DEC'(1) : dec_q;
		start = dbf_pkg::CFG_W_MW'((12'(mw_eff) >> 1) + ((12'(fw_eff) + 12'd1) >> 1) - 12'd1);
		limit = signed'(PW'(sl_q)) - signed'(PW'(mw_eff));
	end

	// decisions for the sample in transfer
	always_comb begin
		wr_cur  = in_first ? '0 : wr_q;
		wr_next = ((XW'(wr_cur) + XW'(1)) >= DEPTH_X) ? '0 : wr_cur + AW'(1);
		n       = in_first ? '0 : count_q;
		phase   = in_first ? '0 : phase_q;
		outc    = in_first ? '0 : outcnt_q;
		pos     = in_first ? '0 : pos_q;
		started = n >= CW'(start);
		ph0     = (n == CW'(start)) ? '0 : phase;
		ph_inc  = {1'b0, ph0} + (dbf_pkg::PHASE_W+1)'(1);
		ph_next = (ph_inc >= (dbf_pkg::PHASE_W+1)'(dec_eff)) ? '0 :
			ph_inc[dbf_pkg::PHASE_W-1:0];
		pos_x   = signed'(PW'(pos));
		emit    = started && (ph0 == '0) && (pos_x <= limit);
		item_ctl.emit     = emit;
		item_ctl.last     = (pos_x + signed'(PW'(dec_eff))) > limit;
		item_ctl.first    = in_first;
		item_ctl.leave_ok = n >= CW'(fw_eff);
	end

	// handshake
	assign busy     = rs_active_q || rs_add_q || dec_fix_q;
	assign in_ready = take_ok && !busy;
	assign accept   = in_valid && in_ready;

	// series counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			count_q  <= '0;
			phase_q  <= '0;
			outcnt_q <= '0;
			pos_q    <= '0;
		end else if (accept) begin
			wr_q    <= wr_next;
			count_q <= (n == dbf_pkg::CNT_MAX) ? n : n + CW'(1);
			phase_q <= started ? ph_next : phase;
			if (emit) begin
				outcnt_q <= (outc == dbf_pkg::CNT_MAX) ? outc : outc + CW'(1);
				pos_q    <= pos + dbf_pkg::POS_W'(dec_eff);
			end else begin
				outcnt_q <= outc;
				pos_q    <= pos;
			end
		end else if (dec_fix_q) begin
			pos_q <= dbf_pkg::POS_W'(outcnt_q * dec_eff);
		end
	end

	// new decimation: flag the write, then rescale the result position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_fix_q <= 1'b0;
		end else begin
			dec_fix_q <= cfg_wr_en && (cfg_index == dbf_pkg::REG_DECIMATION);
		end
	end

	// window re-sum sweep after a width change, newest entry first
	assign rs_start = cfg_wr_en && ((cfg_index == dbf_pkg::REG_FILTER_WIDTH) ||
		(cfg_index == dbf_pkg::REG_MAX_WIDTH));
	assign rs_issue = rs_active_q && (rs_k_q < XW'(fw_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_active_q <= 1'b0;
			rs_add_q    <= 1'b0;
			rs_k_q      <= '0;
		end else if (rs_start) begin
			rs_active_q <= 1'b1;
			rs_add_q    <= 1'b0;
			rs_k_q      <= '0;
		end else if (rs_issue) begin
			rs_k_q   <= rs_k_q + XW'(1);
			rs_add_q <= CW'(rs_k_q) < count_q;
		end else begin
			rs_active_q <= 1'b0;
			rs_add_q    <= 1'b0;
		end
	end

	assign sweep.clr = rs_start;
	assign sweep.add = rs_add_q;

	// delay-line port: samples write, leaving sample or sweep reads
	assign ram_we    = accept;
	assign ram_waddr = wr_cur;
	assign ram_re    = accept || rs_issue;
	assign ram_raddr = accept ? ring_back(wr_cur, XW'(fw_eff)) :
		ring_back(wr_q, rs_k_q + XW'(1));

`include "decimated_boxcar_filter_macros.svh"

	`DBF_ASSERT_NEXT(a_count_step, accept && !in_first && (count_q != dbf_pkg::CNT_MAX), count_q == $past(count_q) + CW'(1), "sample count did not advance")
	`DBF_ASSERT_NOW(a_sweep_bound, rs_active_q, rs_k_q <= XW'(fw_eff), "re-sum sweep ran past the window")

endmodule

>>> rtl/dbf_accum.sv
// Running window sum stage and result register.
`timescale 1ns / 1ps

module dbf_accum #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              accept,
	input  logic signed [SAMPLE_BITS-1:0]     sample_in,
	input  dbf_pkg::item_ctl_t                item_ctl,
	input  dbf_pkg::sweep_ctl_t               sweep,
	input  logic signed [SAMPLE_BITS-1:0]     ram_rdata,
	output logic                              take_ok,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [dbf_pkg::SUM_W-1:0]  boxcar_sum,
	output logic                              last_result
);

	localparam int SW = dbf_pkg::SUM_W;

	logic                          s1_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	dbf_pkg::item_ctl_t            ctl_s1;
	logic signed [SW-1:0]          sum_q, sum_new, base, leave;
	logic                          s1_adv;
	logic                          out_valid_q, out_last_q;
	logic signed [SW-1:0]          out_sum_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_in;
			ctl_s1    <= item_ctl;
		end
	end

	// new sum: add entering sample, drop the one leaving the window
	always_comb begin
		base    = ctl_s1.first ? '0 : sum_q;
		leave   = ctl_s1.leave_ok ? SW'(ram_rdata) : '0;
		sum_new = base + SW'(sample_s1) - leave;
	end

	assign s1_adv  = s1_valid_q && (!ctl_s1.emit || !out_valid_q || out_ready);
	assign take_ok = !s1_valid_q || s1_adv;

	// window sum: sweep clear/add or per-sample update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (sweep.clr) begin
			sum_q <= '0;
		end else if (sweep.add) begin
			sum_q <= sum_q + SW'(ram_rdata);
		end else if (s1_adv) begin
			sum_q <= sum_new;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && ctl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ctl_s1.emit) begin
			out_sum_q  <= sum_new;
			out_last_q <= ctl_s1.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign boxcar_sum  = out_sum_q;
	assign last_result = out_last_q;

`include "decimated_boxcar_filter_macros.svh"

	`DBF_ASSERT_NEXT(a_hold_blocked, s1_valid_q && ctl_s1.emit && out_valid_q && !out_ready, s1_valid_q && out_valid_q, "blocked result was dropped")
	`DBF_ASSERT_NEXT(a_sweep_clear, sweep.clr, sum_q == '0, "window sum not cleared for re-sum")

endmodule

>>> rtl/decimated_boxcar_filter.sv
// Top level of the decimating boxcar (moving-sum) filter.
`timescale 1ns / 1ps

// Decimating boxcar filter. Each input transfer carries one signed sample (tuser marks the
// first sample of a series); the block keeps the sum of the newest window-width samples in a
// running register fed by a MAX_WINDOW-deep delay-line RAM, and emits that sum every
// decimation samples once the window centered at half the search width is full, flagging
// the final result of the series on tlast. One sample is taken every clock cycle while the
// input is not held off and the result stream is not stalled; a result passes through the
// input register and the result register before it appears on the master side. The delay line
// has one read port: after a write to the window width or the search width register the input
// is held off while the window sum is rebuilt from it, and after a write to decimation while
// the result position is rescaled. No clearing pass is needed after reset.
module decimated_boxcar_filter #(
	parameter int MAX_WINDOW  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,  // sample
	input  logic                                s_tuser,  // first_sample
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dbf_pkg::OUT_TDATA_W-1:0]     m_tdata,  // boxcar_sum
	output logic                                m_tlast,  // last_result
	// configuration writes
	input  logic                                cfg_wr_en,
	input  logic [dbf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dbf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW = $clog2(MAX_WINDOW);

	logic                          accept, take_ok;
	dbf_pkg::item_ctl_t            item_ctl;
	dbf_pkg::sweep_ctl_t           sweep;
	logic                          ram_we, ram_re;
	logic [AW-1:0]                 ram_waddr, ram_raddr;
	logic [SAMPLE_BITS-1:0]        ram_rdata;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic signed [dbf_pkg::SUM_W-1:0] boxcar_sum;

	assign sample = signed'(s_tdata[SAMPLE_BITS-1:0]);

	dbf_ctrl #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_first  (s_tuser),
		.take_ok   (take_ok),
		.in_ready  (s_tready),
		.accept    (accept),
		.item_ctl  (item_ctl),
		.sweep     (sweep),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	// delay line of recent samples
	dbf_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(MAX_WINDOW)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_tdata[SAMPLE_BITS-1:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dbf_accum #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sample_in   (sample),
		.item_ctl    (item_ctl),
		.sweep       (sweep),
		.ram_rdata   (signed'(ram_rdata)),
		.take_ok     (take_ok),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.boxcar_sum  (boxcar_sum),
		.last_result (m_tlast)
	);

	assign m_tdata = {{(dbf_pkg::OUT_TDATA_W - dbf_pkg::SUM_W){1'b0}}, boxcar_sum};

endmodule
